@@ rtl/sjfd_pkg.sv @@
// Shared types and constants of the shortest-job-first dispatcher.
// Used by sjf_nonpreemptive_dispatcher; depends on nothing else.
package sjfd_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int CMP_W    = CNT_W + 1;

  localparam int OP_W     = 2;
  localparam int ID_W     = 16;
  localparam int ARR_W    = 16;
  localparam int BURST_W  = 16;
  localparam int KIND_W   = 3;
  localparam int TIME_W   = 24;

  localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] LIMIT_RESET = TIME_W'(100);

  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int REG_LSB = 2;
  localparam logic [ADDR_W-REG_LSB-1:0] REG_IDLE_LIMIT = '0;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_CLEAR    = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    EV_SERVED  = 3'd0,
    EV_IDLE    = 3'd1,
    EV_DONE    = 3'd2,
    EV_STOPPED = 3'd3,
    EV_FULL    = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADM_CHK,
    ST_SCAN_Q,
    ST_SCAN_J,
    ST_COMP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [ID_W-1:0]    job_id;
    logic [ARR_W-1:0]   arrival_time;
    logic [BURST_W-1:0] burst_length;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [ID_W-1:0]   served_id;
    logic [TIME_W-1:0] event_time;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
  } job_t;

endpackage

@@ rtl/sjfd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; holds the job store and the ready queue of the dispatcher.
module sjfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/sjf_nonpreemptive_dispatcher.sv @@
// Non-preemptive shortest-job-first dispatcher: job store and ready queue in RAM.
// Depends on sjfd_pkg and sjfd_ram.
//
//  channel  | ports                                  | beat taken when
//  ---------+----------------------------------------+------------------------------
//  command  | start, busy, cmd                       | start high, busy low
//  result   | result_strobe, result                  | the cycle result_strobe is high
//  config   | psel, penable, pwrite, paddr, pwdata,  | psel, penable, pwrite, pready
//           | prdata, pready                         |
//
// Add, clear, the rejected add and the stopped dispatch leave busy low.
// A dispatch admits the arrived jobs to the queue, one store read per job admitted, then
// reports an idle slot or the end, or scans the ready jobs (a queue read, then a store
// read, per entry), shifts the queue entries above the chosen one down one place and
// serves it; the result beat follows in the first cycle with busy low.
// Reset empties the store, queue and time; the memories need no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sjf_nonpreemptive_dispatcher (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  sjfd_pkg::cmd_t                   cmd,
  output logic                             result_strobe,
  output sjfd_pkg::result_t                result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sjfd_pkg::ADDR_W-1:0]      paddr,
  input  logic [sjfd_pkg::DATA_W-1:0]      pwdata,
  output logic [sjfd_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  sjfd_pkg::state_t state, state_next;

  logic [sjfd_pkg::CNT_W-1:0]   jobs_loaded, jobs_loaded_next;
  logic [sjfd_pkg::CNT_W-1:0]   next_to_admit, next_to_admit_next;
  logic [sjfd_pkg::CNT_W-1:0]   ready_count, ready_count_next;
  logic [sjfd_pkg::TIME_W-1:0]  current_time, current_time_next;
  logic                         halted, halted_next;
  logic [sjfd_pkg::TIME_W-1:0]  idle_time_limit;
  logic [sjfd_pkg::IDX_W-1:0]   scan_k, scan_k_next;
  logic [sjfd_pkg::IDX_W-1:0]   best_k, best_k_next;
  logic [sjfd_pkg::BURST_W-1:0] best_burst, best_burst_next;
  logic [sjfd_pkg::ID_W-1:0]    best_id, best_id_next;
  logic                         result_strobe_next;
  sjfd_pkg::result_t            result_next;

  logic                         job_we;
  logic [sjfd_pkg::IDX_W-1:0]   job_waddr, job_raddr;
  sjfd_pkg::job_t               job_wdata, job_rdata;
  logic                         rq_we;
  logic [sjfd_pkg::IDX_W-1:0]   rq_waddr, rq_wdata, rq_raddr, rq_rdata;

  logic                         accept;
  logic                         cfg_write;
  logic                         reg_hit;

  assign busy      = (state != sjfd_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign reg_hit   = (paddr[sjfd_pkg::ADDR_W-1:sjfd_pkg::REG_LSB] == sjfd_pkg::REG_IDLE_LIMIT);
  assign cfg_write = psel && penable && pwrite && pready && reg_hit;
  assign prdata    = reg_hit ? sjfd_pkg::DATA_W'(idle_time_limit) : '0;

  sjfd_ram #(
    .WIDTH($bits(sjfd_pkg::job_t)),
    .DEPTH(sjfd_pkg::MAX_JOBS)
  ) u_job_store (
    .clk  (clk),
    .we   (job_we),
    .waddr(job_waddr),
    .wdata(job_wdata),
    .raddr(job_raddr),
    .rdata(job_rdata)
  );

  sjfd_ram #(
    .WIDTH(sjfd_pkg::IDX_W),
    .DEPTH(sjfd_pkg::MAX_JOBS)
  ) u_ready_queue (
    .clk  (clk),
    .we   (rq_we),
    .waddr(rq_waddr),
    .wdata(rq_wdata),
    .raddr(rq_raddr),
    .rdata(rq_rdata)
  );

  always_comb begin
    logic [sjfd_pkg::CMP_W-1:0]  k_w, k1_w, k2_w, rc_w, nb1_w;
    logic [sjfd_pkg::CNT_W-1:0]  nta_inc;
    logic [sjfd_pkg::TIME_W:0]   served_sum;
    logic [sjfd_pkg::TIME_W-1:0] served_time, idle_time;
    logic                        admit_ok, take;
    logic [sjfd_pkg::IDX_W-1:0]  nb_k;

    k_w         = sjfd_pkg::CMP_W'(scan_k);
    k1_w        = k_w + sjfd_pkg::CMP_W'(1);
    k2_w        = k_w + sjfd_pkg::CMP_W'(2);
    rc_w        = sjfd_pkg::CMP_W'(ready_count);
    nta_inc     = next_to_admit + sjfd_pkg::CNT_W'(1);
    served_sum  = {1'b0, current_time} + (sjfd_pkg::TIME_W + 1)'(best_burst);
    served_time = served_sum[sjfd_pkg::TIME_W] ? sjfd_pkg::TIME_MAX
                                               : served_sum[sjfd_pkg::TIME_W-1:0];
    idle_time   = (current_time == sjfd_pkg::TIME_MAX) ? current_time
                                                       : current_time + sjfd_pkg::TIME_W'(1);
    admit_ok    = (next_to_admit < jobs_loaded) &&
                  (ready_count < sjfd_pkg::CNT_W'(sjfd_pkg::MAX_JOBS)) &&
                  (sjfd_pkg::TIME_W'(job_rdata.arrival) <= current_time);
    take        = (scan_k == '0) || (best_burst > job_rdata.burst);
    nb_k        = take ? scan_k : best_k;
    nb1_w       = sjfd_pkg::CMP_W'(nb_k) + sjfd_pkg::CMP_W'(1);

    state_next         = state;
    jobs_loaded_next   = jobs_loaded;
    next_to_admit_next = next_to_admit;
    ready_count_next   = ready_count;
    current_time_next  = current_time;
    halted_next        = halted;
    scan_k_next        = scan_k;
    best_k_next        = best_k;
    best_burst_next    = best_burst;
    best_id_next       = best_id;
    result_strobe_next = 1'b0;
    result_next        = result;

    job_we    = 1'b0;
    job_waddr = jobs_loaded[sjfd_pkg::IDX_W-1:0];
    job_wdata = '{id: cmd.job_id, arrival: cmd.arrival_time, burst: cmd.burst_length};
    job_raddr = next_to_admit[sjfd_pkg::IDX_W-1:0];
    rq_we     = 1'b0;
    rq_waddr  = ready_count[sjfd_pkg::IDX_W-1:0];
    rq_wdata  = next_to_admit[sjfd_pkg::IDX_W-1:0];
    rq_raddr  = '0;

    case (state)
      sjfd_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd.operation)
            sjfd_pkg::OP_ADD: begin
              if (jobs_loaded >= sjfd_pkg::CNT_W'(sjfd_pkg::MAX_JOBS)) begin
                result_strobe_next = 1'b1;
                result_next = '{event_kind: sjfd_pkg::EV_FULL, served_id: '0, event_time: '0};
              end else begin
                job_we           = 1'b1;
                jobs_loaded_next = jobs_loaded + sjfd_pkg::CNT_W'(1);
              end
            end
            sjfd_pkg::OP_DISPATCH: begin
              if (halted) begin
                result_strobe_next = 1'b1;
                result_next = '{event_kind: sjfd_pkg::EV_STOPPED, served_id: '0,
                                event_time: current_time};
              end else begin
                // The store read of the first candidate is issued in this cycle.
                state_next = sjfd_pkg::ST_ADM_CHK;
              end
            end
            sjfd_pkg::OP_CLEAR: begin
              jobs_loaded_next   = '0;
              next_to_admit_next = '0;
              ready_count_next   = '0;
              current_time_next  = '0;
              halted_next        = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      sjfd_pkg::ST_ADM_CHK: begin
        if (admit_ok) begin
          rq_we              = 1'b1;
          ready_count_next   = ready_count + sjfd_pkg::CNT_W'(1);
          next_to_admit_next = nta_inc;
          job_raddr          = nta_inc[sjfd_pkg::IDX_W-1:0];
        end else if (ready_count == '0) begin
          result_strobe_next = 1'b1;
          state_next         = sjfd_pkg::ST_IDLE;
          if (next_to_admit >= jobs_loaded) begin
            result_next = '{event_kind: sjfd_pkg::EV_DONE, served_id: '0,
                            event_time: current_time};
          end else begin
            result_next = '{event_kind: sjfd_pkg::EV_IDLE, served_id: '0,
                            event_time: current_time};
            current_time_next = idle_time;
            if (idle_time > idle_time_limit) begin
              halted_next = 1'b1;
            end
          end
        end else begin
          scan_k_next = '0;
          rq_raddr    = '0;
          state_next  = sjfd_pkg::ST_SCAN_Q;
        end
      end

      sjfd_pkg::ST_SCAN_Q: begin
        job_raddr  = rq_rdata;
        state_next = sjfd_pkg::ST_SCAN_J;
      end

      sjfd_pkg::ST_SCAN_J: begin
        // Strict compare keeps the earliest admitted job on equal bursts.
        best_k_next = nb_k;
        if (take) begin
          best_burst_next = job_rdata.burst;
          best_id_next    = job_rdata.id;
        end
        if (k1_w < rc_w) begin
          scan_k_next = k1_w[sjfd_pkg::IDX_W-1:0];
          rq_raddr    = k1_w[sjfd_pkg::IDX_W-1:0];
          state_next  = sjfd_pkg::ST_SCAN_Q;
        end else begin
          scan_k_next = nb_k;
          if (nb1_w < rc_w) begin
            rq_raddr   = nb1_w[sjfd_pkg::IDX_W-1:0];
            state_next = sjfd_pkg::ST_COMP;
          end else begin
            state_next = sjfd_pkg::ST_FINISH;
          end
        end
      end

      sjfd_pkg::ST_COMP: begin
        // The entry above is read in the previous cycle and written one place down.
        rq_we       = 1'b1;
        rq_waddr    = scan_k;
        rq_wdata    = rq_rdata;
        scan_k_next = k1_w[sjfd_pkg::IDX_W-1:0];
        if (k2_w < rc_w) begin
          rq_raddr = k2_w[sjfd_pkg::IDX_W-1:0];
        end else begin
          state_next = sjfd_pkg::ST_FINISH;
        end
      end

      sjfd_pkg::ST_FINISH: begin
        current_time_next  = served_time;
        ready_count_next   = ready_count - sjfd_pkg::CNT_W'(1);
        result_strobe_next = 1'b1;
        result_next = '{event_kind: sjfd_pkg::EV_SERVED, served_id: best_id,
                        event_time: served_time};
        state_next  = sjfd_pkg::ST_IDLE;
      end

      default: begin
        state_next = sjfd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sjfd_pkg::ST_IDLE;
      jobs_loaded   <= '0;
      next_to_admit <= '0;
      ready_count   <= '0;
      current_time  <= '0;
      halted        <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      jobs_loaded   <= jobs_loaded_next;
      next_to_admit <= next_to_admit_next;
      ready_count   <= ready_count_next;
      current_time  <= current_time_next;
      halted        <= halted_next;
      result_strobe <= result_strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_k     <= scan_k_next;
    best_k     <= best_k_next;
    best_burst <= best_burst_next;
    best_id    <= best_id_next;
    result     <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_time_limit <= sjfd_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      idle_time_limit <= pwdata[sjfd_pkg::TIME_W-1:0];
    end
  end

  a_queue_within_admitted: assert property (@(posedge clk) disable iff (rst)
    ready_count <= next_to_admit)
    else $error("ready queue holds more jobs than were admitted");

  a_admitted_within_loaded: assert property (@(posedge clk) disable iff (rst)
    next_to_admit <= jobs_loaded)
    else $error("admission ran past the loaded jobs");

  a_scan_needs_ready: assert property (@(posedge clk) disable iff (rst)
    (state == sjfd_pkg::ST_SCAN_Q || state == sjfd_pkg::ST_SCAN_J ||
     state == sjfd_pkg::ST_COMP || state == sjfd_pkg::ST_FINISH) |-> ready_count != '0)
    else $error("selection running with an empty ready queue");

  a_halt_only_cleared: assert property (@(posedge clk) disable iff (rst)
    $fell(halted) |-> ($past(rst) ||
                       $past(accept && cmd.operation == sjfd_pkg::OP_CLEAR)))
    else $error("halt released without a clear");

endmodule
